@@ design/lcq_pkg.sv @@
`timescale 1ns / 1ps

package lcq_pkg;

    // Field and state widths
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned SUM_W      = 16;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned WAIT_W     = 8;
    localparam int unsigned BIAS_W     = 13;
    localparam int unsigned CONTRAST_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 13;

    // Default block size and ladder length
    localparam int unsigned AVERAGE_COUNT_DEF   = 10;
    localparam int unsigned THRESHOLD_COUNT_DEF = 15;
    localparam int unsigned LADDER_MAX          = 15;

    // Register reset values
    localparam logic [BIAS_W-1:0]   BIAS_RESET   = '0;
    localparam logic [SAMPLE_W-1:0] BRIGHT_RESET = 12'd3100;
    localparam logic [WAIT_W-1:0]   WAIT_RESET   = 8'd20;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_OFFSET      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT       = 2'd2;

    // Ascending contrast ladder
    typedef logic [SAMPLE_W-1:0] ladder_t [LADDER_MAX];
    localparam ladder_t LADDER = '{
        12'd3500, 12'd3770, 12'd3772, 12'd3774, 12'd3776, 12'd3778, 12'd3780, 12'd3785,
        12'd3790, 12'd3795, 12'd3810, 12'd3830, 12'd3850, 12'd3870, 12'd3900
    };

    // Per-item flags as they travel down the pipe
    typedef struct packed {
        logic bright;
        logic restart;
        logic updated;
    } lcq_flags_t;

    // Accumulate stage to ladder stage
    typedef struct packed {
        lcq_flags_t       flags;
        logic [SUM_W-1:0] block_sum;
    } lcq_stage_t;

endpackage

@@ design/lcq_accum.sv @@
`timescale 1ns / 1ps

module lcq_accum #(
    parameter int unsigned AVERAGE_COUNT = lcq_pkg::AVERAGE_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lcq_pkg::SAMPLE_W-1:0]  bright_threshold,
    input  logic [lcq_pkg::WAIT_W-1:0]    wait_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic [lcq_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                          st_valid,
    input  logic                          st_ready,
    output lcq_pkg::lcq_stage_t           st_data
);

    logic [lcq_pkg::SUM_W-1:0]   sample_sum_reg,    sample_sum_next;
    logic [lcq_pkg::COUNT_W-1:0] samples_taken_reg, samples_taken_next;
    logic [lcq_pkg::WAIT_W-1:0]  wait_ticks_reg,    wait_ticks_next;
    logic                        st_valid_reg;
    lcq_pkg::lcq_stage_t         st_data_reg,       st_data_next;

    logic                        in_xfer;
    logic [lcq_pkg::COUNT_W:0]   count_inc;
    logic [lcq_pkg::WAIT_W:0]    wait_inc;
    logic [lcq_pkg::SUM_W-1:0]   sum_inc;

    assign in_ready = !st_valid_reg || st_ready;
    assign in_xfer  = in_valid && in_ready;
    assign st_valid = st_valid_reg;
    assign st_data  = st_data_reg;

    // Running sum, sample count and wait counter for one item
    always_comb begin
        sample_sum_next    = sample_sum_reg;
        samples_taken_next = samples_taken_reg;
        wait_ticks_next    = wait_ticks_reg;
        st_data_next       = '0;
        sum_inc   = sample_sum_reg + lcq_pkg::SUM_W'(in_sample);
        count_inc = {1'b0, samples_taken_reg} + 1'b1;
        wait_inc  = {1'b0, wait_ticks_reg} + 1'b1;
        if (!in_action) begin
            wait_ticks_next             = '0;
            st_data_next.flags.bright   = in_sample > bright_threshold;
            if (count_inc >= (lcq_pkg::COUNT_W+1)'(AVERAGE_COUNT)) begin
                st_data_next.flags.updated = 1'b1;
                st_data_next.block_sum     = sum_inc;
                sample_sum_next            = '0;
                samples_taken_next         = '0;
            end else begin
                sample_sum_next    = sum_inc;
                samples_taken_next = count_inc[lcq_pkg::COUNT_W-1:0];
            end
        end else begin
            if (wait_inc > {1'b0, wait_limit}) begin
                st_data_next.flags.restart = 1'b1;
                wait_ticks_next            = '0;
            end else begin
                wait_ticks_next = wait_inc[lcq_pkg::WAIT_W-1:0];
            end
        end
    end

    // State and stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_sum_reg    <= '0;
            samples_taken_reg <= '0;
            wait_ticks_reg    <= '0;
            st_valid_reg      <= 1'b0;
        end else begin
            if (in_xfer) begin
                sample_sum_reg    <= sample_sum_next;
                samples_taken_reg <= samples_taken_next;
                wait_ticks_reg    <= wait_ticks_next;
            end
            if (in_ready) begin
                st_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            st_data_reg <= st_data_next;
        end
    end

endmodule

@@ design/lcq_ladder.sv @@
`timescale 1ns / 1ps

module lcq_ladder #(
    parameter int unsigned AVERAGE_COUNT   = lcq_pkg::AVERAGE_COUNT_DEF,
    parameter int unsigned THRESHOLD_COUNT = lcq_pkg::THRESHOLD_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lcq_pkg::BIAS_W-1:0]      bias_offset,
    input  logic                            st_valid,
    output logic                            st_ready,
    input  lcq_pkg::lcq_stage_t             st_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lcq_pkg::CONTRAST_W-1:0]  out_contrast,
    output lcq_pkg::lcq_flags_t             out_flags
);

    // Reciprocal divide: exact for any 16-bit sum with this shift
    localparam int unsigned SHIFT  = lcq_pkg::SUM_W + $clog2(AVERAGE_COUNT);
    localparam int unsigned PROD_W = lcq_pkg::SUM_W + SHIFT + 1;
    localparam int unsigned LVL_W  = lcq_pkg::SUM_W + 2;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT;
    localparam logic [SHIFT:0] RECIP = RECIP_FULL[SHIFT:0];

    logic [lcq_pkg::CONTRAST_W-1:0] contrast_level_reg, contrast_next;
    logic [lcq_pkg::CONTRAST_W-1:0] ladder_idx;
    logic                           out_valid_reg;
    logic [lcq_pkg::CONTRAST_W-1:0] out_contrast_reg;
    lcq_pkg::lcq_flags_t            out_flags_reg;

    logic                           st_xfer;
    logic [PROD_W-1:0]              product;
    logic [lcq_pkg::SUM_W-1:0]      average;
    logic signed [LVL_W-1:0]        level;

    assign st_ready     = !out_valid_reg || out_ready;
    assign st_xfer      = st_valid && st_ready;
    assign out_valid    = out_valid_reg;
    assign out_contrast = out_contrast_reg;
    assign out_flags    = out_flags_reg;

    // Block average plus bias
    always_comb begin
        product = PROD_W'(st_data.block_sum) * PROD_W'(RECIP);
        average = product[SHIFT +: lcq_pkg::SUM_W];
        level   = $signed({2'b00, average})
                + $signed({{(LVL_W-lcq_pkg::BIAS_W){bias_offset[lcq_pkg::BIAS_W-1]}},
                           bias_offset});
    end

    // First threshold above the level; negative levels clamp to zero
    always_comb begin
        ladder_idx = lcq_pkg::CONTRAST_W'(THRESHOLD_COUNT);
        for (int i = THRESHOLD_COUNT - 1; i >= 0; i--) begin
            if ({{(LVL_W-lcq_pkg::SAMPLE_W){1'b0}}, lcq_pkg::LADDER[i]} > level) begin
                ladder_idx = lcq_pkg::CONTRAST_W'(i);
            end
        end
        if (level[LVL_W-1]) begin
            ladder_idx = '0;
        end
        contrast_next = st_data.flags.updated ? ladder_idx : contrast_level_reg;
    end

    // Contrast state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            contrast_level_reg <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            if (st_xfer) begin
                contrast_level_reg <= contrast_next;
            end
            if (st_ready) begin
                out_valid_reg <= st_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st_xfer) begin
            out_contrast_reg <= contrast_next;
            out_flags_reg    <= st_data.flags;
        end
    end

endmodule

@@ design/light_level_contrast_quantizer_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: an accumulate stage, then a reciprocal divide, bias add and ladder
// compare stage, each ending in a register.
// Throughput: one item per cycle; both stages advance when the result
// register is empty or being taken.
// Reset: aresetn low at a clock edge clears sums, counters, contrast,
// pipeline valids and loads the register defaults.

module light_level_contrast_quantizer_unit #(
    parameter int unsigned AVERAGE_COUNT   = lcq_pkg::AVERAGE_COUNT_DEF,
    parameter int unsigned THRESHOLD_COUNT = lcq_pkg::THRESHOLD_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration writes
    input  logic                             cfg_we,
    input  logic [lcq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lcq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [11:0] sample
    input  logic                             s_tuser,   // [0] action
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [3:0] contrast
    output logic [2:0]                       m_tuser    // [0] level_updated,
                                                        // [1] restart_converter,
                                                        // [2] bright_seen
);

    logic [lcq_pkg::BIAS_W-1:0]     bias_offset_reg;
    logic [lcq_pkg::SAMPLE_W-1:0]   bright_threshold_reg;
    logic [lcq_pkg::WAIT_W-1:0]     wait_limit_reg;

    logic                           st_valid;
    logic                           st_ready;
    lcq_pkg::lcq_stage_t            st_data;
    logic [lcq_pkg::CONTRAST_W-1:0] contrast;
    lcq_pkg::lcq_flags_t            flags;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_offset_reg      <= lcq_pkg::BIAS_RESET;
            bright_threshold_reg <= lcq_pkg::BRIGHT_RESET;
            wait_limit_reg       <= lcq_pkg::WAIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lcq_pkg::CFG_BIAS_OFFSET: begin
                    bias_offset_reg <= cfg_wdata;
                end
                lcq_pkg::CFG_BRIGHT_THRESHOLD: begin
                    bright_threshold_reg <= cfg_wdata[lcq_pkg::SAMPLE_W-1:0];
                end
                lcq_pkg::CFG_WAIT_LIMIT: begin
                    wait_limit_reg <= cfg_wdata[lcq_pkg::WAIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    lcq_accum #(
        .AVERAGE_COUNT (AVERAGE_COUNT)
    ) u_accum (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .bright_threshold (bright_threshold_reg),
        .wait_limit       (wait_limit_reg),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_action        (s_tuser),
        .in_sample        (s_tdata[lcq_pkg::SAMPLE_W-1:0]),
        .st_valid         (st_valid),
        .st_ready         (st_ready),
        .st_data          (st_data)
    );

    lcq_ladder #(
        .AVERAGE_COUNT   (AVERAGE_COUNT),
        .THRESHOLD_COUNT (THRESHOLD_COUNT)
    ) u_ladder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bias_offset  (bias_offset_reg),
        .st_valid     (st_valid),
        .st_ready     (st_ready),
        .st_data      (st_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_contrast (contrast),
        .out_flags    (flags)
    );

    assign m_tdata = {4'b0000, contrast};
    assign m_tuser = {flags.bright, flags.restart, flags.updated};

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    // Codes of the action field
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_WAIT   = 1'b1;

    // Samples per averaged block and the contrast ladder
    localparam int AVG_LEN = 10;
    localparam int STEP_COUNT = 15;
    localparam int LIGHT_STEPS [STEP_COUNT] = '{
        3500, 3770, 3772, 3774, 3776, 3778, 3780, 3785,
        3790, 3795, 3810, 3830, 3850, 3870, 3900
    };

    // One result item as the block reports it
    typedef struct packed {
        logic [3:0] contrast;
        logic       bright;
        logic       restart;
        logic       updated;
    } light_result_t;

    // Tracks the block state, predicts each result and checks it on arrival
    class contrast_scoreboard;
        logic signed [12:0] bias;
        logic [11:0]        bright_thr;
        logic [7:0]         wait_lim;
        logic [15:0]        sum;
        logic [3:0]         taken;
        logic [7:0]         ticks;
        logic [3:0]         level;
        light_result_t      expected_q[$];
        int                 errors;
        int                 results;
        int                 updates;
        int                 restarts;
        int                 brights;

        function new();
            bias       = lcq_pkg::BIAS_RESET;
            bright_thr = lcq_pkg::BRIGHT_RESET;
            wait_lim   = lcq_pkg::WAIT_RESET;
            sum        = '0;
            taken      = '0;
            ticks      = '0;
            level      = '0;
            errors     = 0;
            results    = 0;
            updates    = 0;
            restarts   = 0;
            brights    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] data);
            case (idx)
                lcq_pkg::CFG_BIAS_OFFSET:      bias = data;
                lcq_pkg::CFG_BRIGHT_THRESHOLD: bright_thr = data[11:0];
                lcq_pkg::CFG_WAIT_LIMIT:       wait_lim = data[7:0];
                default: ;
            endcase
        endfunction

        // First step strictly above the level; negative levels clamp to 0
        function logic [3:0] ladder_level(int lvl);
            if (lvl < 0) return 4'd0;
            for (int i = 0; i < STEP_COUNT; i++) begin
                if (LIGHT_STEPS[i] > lvl) return 4'(i);
            end
            return 4'(STEP_COUNT);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void note_input(logic action, logic [11:0] reading);
            light_result_t r;
            int            avg;
            int            nxt;
            r = '0;
            if (action == ACT_SAMPLE) begin
                ticks = '0;
                sum = sum + 16'(reading);
                r.bright = (reading > bright_thr);
                if (int'(taken) + 1 >= AVG_LEN) begin
                    avg = int'(sum) / AVG_LEN;
                    level = ladder_level(avg + int'(bias));
                    r.updated = 1'b1;
                    sum = '0;
                    taken = '0;
                end else begin
                    taken = taken + 4'd1;
                end
            end else begin
                // wait tick: the sum and sample count survive a restart
                nxt = int'(ticks) + 1;
                if (nxt > int'(wait_lim)) begin
                    r.restart = 1'b1;
                    ticks = '0;
                end else begin
                    ticks = 8'(nxt);
                end
            end
            r.contrast = level;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("tb: mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [7:0] tdata, logic [2:0] tuser);
            light_result_t got;
            light_result_t exp_r;
            got.contrast = tdata[3:0];
            got.updated  = tuser[0];
            got.restart  = tuser[1];
            got.bright   = tuser[2];
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result contrast %0d flags %b",
                                 got.contrast, tuser));
            end else begin
                exp_r = expected_q.pop_front();
                results++;
                if (got.contrast !== exp_r.contrast)
                    report($sformatf("result %0d contrast %0d, want %0d",
                                     results, got.contrast, exp_r.contrast));
                if (got.updated !== exp_r.updated)
                    report($sformatf("result %0d level_updated %b, want %b",
                                     results, got.updated, exp_r.updated));
                if (got.restart !== exp_r.restart)
                    report($sformatf("result %0d restart_converter %b, want %b",
                                     results, got.restart, exp_r.restart));
                if (got.bright !== exp_r.bright)
                    report($sformatf("result %0d bright_seen %b, want %b",
                                     results, got.bright, exp_r.bright));
                updates  += exp_r.updated;
                restarts += exp_r.restart;
                brights  += exp_r.bright;
            end
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [11:0] sample
    logic        s_tuser = 1'b0;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [3:0] contrast
    logic [2:0]  m_tuser;          // [0] level_updated, [1] restart_converter, [2] bright_seen

    contrast_scoreboard sb = new();

    int items_sent = 0;
    int cfg_writes = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold = 0;

    light_level_contrast_quantizer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // Watch both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata[11:0]);
        end
    end

    // Result side: random stalls, plus a long hold-off when asked
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = rx_quiet ? 0 : $urandom_range(0, 4);
            if (rx_hold > 0) begin
                stall = rx_hold;
                rx_hold = 0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one item after a random gap and hold it until the transfer
    task send_item(logic action, logic [11:0] reading);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {4'b0, reading};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result is back
    task drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task cfg_write(logic [1:0] idx, logic [12:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    task configure(int bias, int bright, int wlim);
        cfg_write(lcq_pkg::CFG_BIAS_OFFSET, 13'(bias));
        cfg_write(lcq_pkg::CFG_BRIGHT_THRESHOLD, 13'(bright));
        cfg_write(lcq_pkg::CFG_WAIT_LIMIT, 13'(wlim));
    endtask

    // Reading close to a chosen light level
    function logic [11:0] near(int center);
        int v;
        v = center + $urandom_range(0, 60) - 30;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    // Mostly blocks of readings around the ladder, some wait runs, some noise
    task random_segment();
        int kind;
        int n;
        int center;
        kind = $urandom_range(0, 9);
        tx_quiet = ($urandom_range(0, 7) == 0);
        rx_quiet = ($urandom_range(0, 7) == 0);
        if (kind < 6) begin
            n = $urandom_range(1, AVG_LEN);
            center = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                 : $urandom_range(3440, 3960);
            repeat (n) send_item(ACT_SAMPLE, near(center));
        end else if (kind < 8) begin
            n = $urandom_range(1, int'(sb.wait_lim) + 2);
            repeat (n) send_item(ACT_WAIT, 12'($urandom_range(0, 4095)));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) send_item(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)));
        end
    endtask

    task run_phase(int n_items, bit squeeze, bit pause);
        int start;
        start = items_sent;
        if (squeeze) begin
            // receiver holds off while the sender keeps pushing
            rx_hold = 80;
            tx_quiet = 1'b1;
            repeat (20) send_item(ACT_SAMPLE, near($urandom_range(3440, 3960)));
        end
        while (items_sent - start < n_items) begin
            random_segment();
            if (pause && items_sent - start >= n_items / 2) begin
                drain();
                pause = 1'b0;
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, threshold edge, ignored wait content
        send_item(ACT_SAMPLE, 12'd0);
        send_item(ACT_SAMPLE, 12'd4095);
        send_item(ACT_SAMPLE, 12'd3100);
        send_item(ACT_SAMPLE, 12'd3101);
        send_item(ACT_WAIT, 12'hFFF);
        repeat (6) send_item(ACT_SAMPLE, 12'd3900);
        drain();
        // restart mid-block keeps the sum; most negative bias clamps to 0
        cfg_write(lcq_pkg::CFG_WAIT_LIMIT, 13'd1);
        cfg_write(lcq_pkg::CFG_BIAS_OFFSET, 13'h1000);
        send_item(ACT_WAIT, 12'd0);
        send_item(ACT_WAIT, 12'd0);
        repeat (3) send_item(ACT_SAMPLE, 12'd4095);
        send_item(ACT_WAIT, 12'hAAA);
        send_item(ACT_WAIT, 12'h555);
        repeat (7) send_item(ACT_SAMPLE, 12'd4095);
        drain();

        // Random phases over a spread of register settings
        configure(0, 0, 1);
        run_phase(250, 1'b1, 1'b0);
        configure(-4096, 4095, 255);
        run_phase(250, 1'b0, 1'b0);
        configure(4095, 3100, 0);
        run_phase(250, 1'b0, 1'b0);
        configure($urandom_range(0, 400) - 200, $urandom_range(0, 4095),
                  $urandom_range(1, 40));
        run_phase(250, 1'b0, 1'b1);
        configure($urandom_range(0, 8191) - 4096, $urandom_range(0, 4095), 3);
        run_phase(250, 1'b0, 1'b0);
        configure(0, 3100, 20);
        run_phase(250, 1'b0, 1'b0);

        $display("tb: %0d items, %0d results, %0d contrast updates, %0d restarts, %0d bright",
                 items_sent, sb.results, sb.updates, sb.restarts, sb.brights);
        $display("tb: %0d register writes across seven settings, %0d mismatches",
                 cfg_writes, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
